FILE: rtl/id3_pkg.sv
// Shared types and constants of the ID3v2 frame text extractor.
// Holds the parse phase encoding, field widths and the result record.
// No dependencies.
`timescale 1ns / 1ps

package id3_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SIZE_W   = 28;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned SS_W     = 7;

    // Header byte positions.
    localparam logic [POS_W-1:0] TAG_SIZE_POS  = 4'd6;
    localparam logic [POS_W-1:0] HDR_LAST_POS  = 4'd9;
    localparam logic [POS_W-1:0] ID_END_POS    = 4'd4;
    localparam logic [POS_W-1:0] SIZE_END_POS  = 4'd8;

    // Default wanted frame ID: "TPE1".
    localparam logic [ID_W-1:0] TARGET_RESET = 32'h5450_4531;

    typedef enum logic [4:0] {
        PH_TAG_HDR   = 5'b00001,
        PH_FRAME_HDR = 5'b00010,
        PH_ENCODING  = 5'b00100,
        PH_CONTENT   = 5'b01000,
        PH_DONE      = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] info_byte;
        logic [BYTE_W-1:0] text_encoding;
        logic              last_byte;
    } t_result;

endpackage

FILE: rtl/id3_parse_core.sv
// Parse state and per-byte next-state logic of the ID3v2 frame walk.
// Produces at most one content byte result per transferred input byte.
// Depends on id3_pkg.
`timescale 1ns / 1ps

module id3_parse_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_take,
    input  logic [id3_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                               i_start_of_file,
    input  logic [id3_pkg::ID_W-1:0]           i_target_id,
    output id3_pkg::t_result                   o_result
);

    id3_pkg::t_phase                   r_phase,     n_phase,     e_phase;
    logic [id3_pkg::POS_W-1:0]         r_pos,       n_pos,       e_pos;
    logic [id3_pkg::SIZE_W-1:0]        r_tag_left,  n_tag_left,  e_tag_left;
    logic [id3_pkg::SIZE_W-1:0]        r_frm_left,  n_frm_left,  e_frm_left;
    logic [id3_pkg::ID_W-1:0]          r_id_shift,  n_id_shift,  e_id_shift;
    logic                              r_found,     n_found,     e_found;
    logic                              r_matches,   n_matches,   e_matches;
    logic [id3_pkg::BYTE_W-1:0]        r_encoding,  n_encoding,  e_encoding;

    logic [id3_pkg::SIZE_W-1:0]        tag_dec;
    logic [id3_pkg::SIZE_W-1:0]        frm_dec;
    logic [id3_pkg::SIZE_W-1:0]        frm_shift;
    logic                              walk_byte;

    // A start mark restarts the parse with this byte as header byte 0.
    always_comb begin
        if (i_start_of_file) begin
            e_phase    = id3_pkg::PH_TAG_HDR;
            e_pos      = '0;
            e_tag_left = '0;
            e_frm_left = '0;
            e_id_shift = '0;
            e_found    = 1'b0;
            e_matches  = 1'b0;
            e_encoding = '0;
        end else begin
            e_phase    = r_phase;
            e_pos      = r_pos;
            e_tag_left = r_tag_left;
            e_frm_left = r_frm_left;
            e_id_shift = r_id_shift;
            e_found    = r_found;
            e_matches  = r_matches;
            e_encoding = r_encoding;
        end
    end

    assign tag_dec   = e_tag_left - id3_pkg::SIZE_W'(1);
    assign frm_dec   = e_frm_left - id3_pkg::SIZE_W'(1);
    assign frm_shift = {e_frm_left[id3_pkg::SIZE_W-id3_pkg::SS_W-1:0],
                        i_data_byte[id3_pkg::SS_W-1:0]};

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_tag_left = r_tag_left;
        n_frm_left = r_frm_left;
        n_id_shift = r_id_shift;
        n_found    = r_found;
        n_matches  = r_matches;
        n_encoding = r_encoding;
        o_result   = '0;
        walk_byte  = 1'b0;
        if (i_take) begin
            n_phase    = e_phase;
            n_pos      = e_pos;
            n_tag_left = e_tag_left;
            n_frm_left = e_frm_left;
            n_id_shift = e_id_shift;
            n_found    = e_found;
            n_matches  = e_matches;
            n_encoding = e_encoding;
            unique case (e_phase)
                id3_pkg::PH_TAG_HDR: begin
                    if (e_pos >= id3_pkg::TAG_SIZE_POS) begin
                        n_tag_left = {e_tag_left[id3_pkg::SIZE_W-id3_pkg::SS_W-1:0],
                                      i_data_byte[id3_pkg::SS_W-1:0]};
                    end
                    if (e_pos >= id3_pkg::HDR_LAST_POS) begin
                        n_pos   = '0;
                        n_phase = (n_tag_left == '0) ? id3_pkg::PH_DONE
                                                     : id3_pkg::PH_FRAME_HDR;
                    end else begin
                        n_pos = e_pos + id3_pkg::POS_W'(1);
                    end
                end
                id3_pkg::PH_FRAME_HDR: begin
                    // Zero first ID byte is padding: stop the walk.
                    if (e_pos == '0 && i_data_byte == '0) begin
                        n_phase = id3_pkg::PH_DONE;
                    end else begin
                        walk_byte = 1'b1;
                        if (e_pos < id3_pkg::ID_END_POS) begin
                            n_id_shift = {e_id_shift[id3_pkg::ID_W-id3_pkg::BYTE_W-1:0],
                                          i_data_byte};
                        end else if (e_pos < id3_pkg::SIZE_END_POS) begin
                            n_frm_left = frm_shift;
                        end
                        if (e_pos >= id3_pkg::HDR_LAST_POS) begin
                            n_pos     = '0;
                            n_matches = !e_found && (e_id_shift == i_target_id);
                            n_found   = e_found || n_matches;
                            n_phase   = (e_frm_left == '0) ? id3_pkg::PH_FRAME_HDR
                                                           : id3_pkg::PH_ENCODING;
                        end else begin
                            n_pos = e_pos + id3_pkg::POS_W'(1);
                        end
                    end
                end
                id3_pkg::PH_ENCODING: begin
                    walk_byte  = 1'b1;
                    n_encoding = i_data_byte;
                    n_frm_left = frm_dec;
                    n_phase    = (frm_dec == '0) ? id3_pkg::PH_FRAME_HDR
                                                 : id3_pkg::PH_CONTENT;
                end
                id3_pkg::PH_CONTENT: begin
                    walk_byte  = 1'b1;
                    n_frm_left = frm_dec;
                    if (e_matches) begin
                        o_result.valid         = 1'b1;
                        o_result.info_byte     = i_data_byte;
                        o_result.text_encoding = e_encoding;
                        o_result.last_byte     = (frm_dec == '0) ||
                                                 (e_tag_left == id3_pkg::SIZE_W'(1));
                    end
                    if (frm_dec == '0) begin
                        n_phase = id3_pkg::PH_FRAME_HDR;
                    end
                end
                default: begin
                    // Done: drop every byte until the next start mark.
                end
            endcase
            // Each byte of the frame walk consumes one tag byte.
            if (walk_byte) begin
                n_tag_left = tag_dec;
                if (tag_dec == '0) begin
                    n_phase = id3_pkg::PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= id3_pkg::PH_TAG_HDR;
            r_pos      <= '0;
            r_tag_left <= '0;
            r_frm_left <= '0;
            r_id_shift <= '0;
            r_found    <= 1'b0;
            r_matches  <= 1'b0;
            r_encoding <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_tag_left <= n_tag_left;
            r_frm_left <= n_frm_left;
            r_id_shift <= n_id_shift;
            r_found    <= n_found;
            r_matches  <= n_matches;
            r_encoding <= n_encoding;
        end
    end

endmodule

FILE: rtl/id3_out_reg.sv
// Result register of the ID3v2 frame text extractor.
// Holds one result until the receiver takes it. Depends on id3_pkg.
`timescale 1ns / 1ps

module id3_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  id3_pkg::t_result              i_result,
    input  logic                          i_out_ready,
    output logic                          o_space,
    output logic                          o_out_valid,
    output logic [id3_pkg::BYTE_W-1:0]    o_info_byte,
    output logic [id3_pkg::BYTE_W-1:0]    o_text_encoding,
    output logic                          o_last_byte
);

    logic                       r_valid, n_valid;
    logic [id3_pkg::BYTE_W-1:0] r_info;
    logic [id3_pkg::BYTE_W-1:0] r_enc;
    logic                       r_last;

    // Room when empty or when the held result leaves this cycle.
    assign o_space = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load && i_result.valid) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_info <= i_result.info_byte;
            r_enc  <= i_result.text_encoding;
            r_last <= i_result.last_byte;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_info_byte     = r_info;
    assign o_text_encoding = r_enc;
    assign o_last_byte     = r_last;

endmodule

FILE: rtl/id3v2_frame_text_extractor.sv
// ID3v2 frame text extractor top level: ID register, parser, result register.
// Depends on id3_pkg, id3_parse_core and id3_out_reg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tag byte per transfer
//   with i_start_of_file marking the first byte of a new file. The parser
//   skips the 10-byte tag header, walks frame headers and emits every content
//   byte of the first frame whose ID equals the ID register.
//   Output channel (o_out_valid / i_out_ready) carries the content byte, the
//   frame's encoding byte and a last mark on the frame's final content byte.
//   The ID register is written through i_cfg_we / i_cfg_data; write it only
//   while no transfer is in flight.
// Result: registered; a result appears in the cycle after its input byte is transferred.
// Throughput: one byte per cycle unless stalled; the per-byte update is one
//   level of counters and compares between parse state and the result register.
// Reset: synchronous, active low; the parse restarts at tag header byte 0,
//   the result register empties and the ID register returns to "TPE1".
// Stall: while a result waits and i_out_ready is low, o_in_ready drops;
//   bytes that produce no result still need the result register free.
`timescale 1ns / 1ps

module id3v2_frame_text_extractor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [id3_pkg::ID_W-1:0]      i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [id3_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_start_of_file,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [id3_pkg::BYTE_W-1:0]    o_info_byte,
    output logic [id3_pkg::BYTE_W-1:0]    o_text_encoding,
    output logic                          o_last_byte
);

    logic [id3_pkg::ID_W-1:0] r_target_id;
    logic                     take;
    logic                     space;
    id3_pkg::t_result         result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= id3_pkg::TARGET_RESET;
        end else if (i_cfg_we) begin
            r_target_id <= i_cfg_data;
        end
    end

    assign o_in_ready = space;
    assign take       = i_in_valid && space;

    id3_parse_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_target_id     (r_target_id),
        .o_result        (result)
    );

    id3_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (take),
        .i_result        (result),
        .i_out_ready     (i_out_ready),
        .o_space         (space),
        .o_out_valid     (o_out_valid),
        .o_info_byte     (o_info_byte),
        .o_text_encoding (o_text_encoding),
        .o_last_byte     (o_last_byte)
    );

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A waiting result blocks new input bytes.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result stalled");

    // A start-of-file byte is a tag header byte and yields no result.
    a_sof_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_start_of_file && i_out_ready)
        |=> !o_out_valid)
        else $error("result produced for a start-of-file byte");

endmodule

FILE: tb/sv/id3_text_checker.sv
// Scoreboard for the ID3v2 frame text extractor: tracks the tag walk per input transfer
// and compares every output transfer with the predicted content byte.
// Depends on id3_pkg.
`timescale 1ns / 1ps

module id3_text_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [id3_pkg::ID_W-1:0]   i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [id3_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_start_of_file,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [id3_pkg::BYTE_W-1:0] i_info_byte,
    input  logic [id3_pkg::BYTE_W-1:0] i_text_encoding,
    input  logic                       i_last_byte,
    output int                         o_bytes_due,
    output int                         o_failures
);
    import id3_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] info;
        logic [BYTE_W-1:0] enc;
        logic              last;
    } text_out_t;

    t_phase             phase;
    logic [POS_W-1:0]   pos;
    logic [SIZE_W-1:0]  tag_left;
    logic [SIZE_W-1:0]  frame_left;
    logic [ID_W-1:0]    id_acc;
    logic [ID_W-1:0]    wanted_id;
    logic               matched_once;
    logic               frame_wanted;
    logic [BYTE_W-1:0]  enc_held;
    text_out_t          text_due[$];
    int                 fail_total = 0;

    assign o_failures = fail_total;

    task automatic restart_parse();
        phase        = PH_TAG_HDR;
        pos          = '0;
        tag_left     = '0;
        frame_left   = '0;
        id_acc       = '0;
        matched_once = 1'b0;
        frame_wanted = 1'b0;
        enc_held     = '0;
    endtask

    // Advance the tag walk by one byte; queue a content byte of the wanted frame.
    task automatic walk_tag_byte(input logic [BYTE_W-1:0] b, input logic sof);
        logic      consumes;
        text_out_t due;
        consumes = 1'b1;
        if (sof)
            restart_parse();
        case (phase)
            PH_TAG_HDR: begin
                consumes = 1'b0;
                if (pos >= TAG_SIZE_POS)
                    tag_left = {tag_left[SIZE_W-SS_W-1:0], b[SS_W-1:0]};
                if (pos >= HDR_LAST_POS) begin
                    pos   = '0;
                    phase = (tag_left == '0) ? PH_DONE : PH_FRAME_HDR;
                end else begin
                    pos = pos + 1'b1;
                end
            end
            PH_FRAME_HDR: begin
                if (pos == '0 && b == '0) begin
                    // padding ends the walk
                    phase    = PH_DONE;
                    consumes = 1'b0;
                end else begin
                    if (pos < ID_END_POS)
                        id_acc = {id_acc[ID_W-BYTE_W-1:0], b};
                    else if (pos < SIZE_END_POS)
                        frame_left = {frame_left[SIZE_W-SS_W-1:0], b[SS_W-1:0]};
                    if (pos >= HDR_LAST_POS) begin
                        pos          = '0;
                        frame_wanted = !matched_once && (id_acc == wanted_id);
                        if (frame_wanted)
                            matched_once = 1'b1;
                        phase = (frame_left == '0) ? PH_FRAME_HDR : PH_ENCODING;
                    end else begin
                        pos = pos + 1'b1;
                    end
                end
            end
            PH_ENCODING: begin
                enc_held   = b;
                frame_left = frame_left - 1'b1;
                phase      = (frame_left == '0) ? PH_FRAME_HDR : PH_CONTENT;
            end
            PH_CONTENT: begin
                frame_left = frame_left - 1'b1;
                if (frame_wanted) begin
                    due.info = b;
                    due.enc  = enc_held;
                    // the tag running out also closes the frame
                    due.last = (frame_left == '0) || (tag_left == 1);
                    text_due.push_back(due);
                end
                if (frame_left == '0)
                    phase = PH_FRAME_HDR;
            end
            default: consumes = 1'b0;
        endcase
        if (consumes) begin
            tag_left = tag_left - 1'b1;
            if (tag_left == '0)
                phase = PH_DONE;
        end
    endtask

    always @(posedge i_clk) begin : watch
        text_out_t due;
        text_out_t got;
        if (!i_rst_n) begin
            wanted_id = TARGET_RESET;
            restart_parse();
            text_due.delete();
        end else begin
            if (i_cfg_we)
                wanted_id = i_cfg_data;
            if (i_in_valid && i_in_ready)
                walk_tag_byte(i_data_byte, i_start_of_file);
            if (i_out_valid && i_out_ready) begin
                got = '{i_info_byte, i_text_encoding, i_last_byte};
                if (text_due.size() == 0) begin
                    $error("unexpected result transfer: info_byte %02h", got.info);
                    fail_total++;
                end else begin
                    due = text_due.pop_front();
                    if (got.info !== due.info) begin
                        $error("info_byte: expected %02h, got %02h", due.info, got.info);
                        fail_total++;
                    end
                    if (got.enc !== due.enc) begin
                        $error("text_encoding: expected %02h, got %02h", due.enc, got.enc);
                        fail_total++;
                    end
                    if (got.last !== due.last) begin
                        $error("last_byte: expected %0b, got %0b", due.last, got.last);
                        fail_total++;
                    end
                end
            end
        end
        o_bytes_due <= text_due.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the ID3v2 frame text extractor bench: clock, reset, tag stream generation,
// ID register writes and output back-pressure; verdict from the checker.
// Depends on id3_pkg, id3v2_frame_text_extractor and id3_text_checker.
`timescale 1ns / 1ps

module testbench;
    import id3_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 280;
    localparam int HOLD_OFF    = 300;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              sof;
        logic              calm;
    } tag_byte_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ID_W-1:0]   cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] data_byte;
    logic              start_mark;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] info_byte;
    logic [BYTE_W-1:0] text_encoding;
    logic              last_byte;
    int                bytes_due;
    int                n_failed;
    int                cycles = 0;
    int                rx_seen = 0;

    logic [BYTE_W-1:0] tag_bytes[$];
    tag_byte_t         byte_plan[$];

    id3v2_frame_text_extractor u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_start_of_file (start_mark),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_info_byte     (info_byte),
        .o_text_encoding (text_encoding),
        .o_last_byte     (last_byte)
    );

    id3_text_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_start_of_file (start_mark),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_info_byte     (info_byte),
        .i_text_encoding (text_encoding),
        .i_last_byte     (last_byte),
        .o_bytes_due     (bytes_due),
        .o_failures      (n_failed)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL id3v2_frame_text_extractor");
            $finish;
        end
    end

    function automatic logic [ID_W-1:0] known_id(input int k);
        case (k)
            0:       return "TIT2";
            1:       return "TPE1";
            2:       return "TALB";
            3:       return "TRCK";
            4:       return "TCON";
            default: return "TYER";
        endcase
    endfunction

    // Syncsafe form of a size; the ignored top bit of each byte is random.
    function automatic logic [31:0] syncsafe(input logic [SIZE_W-1:0] n);
        logic [31:0] w;
        for (int k = 0; k < 4; k++)
            w[k*8 +: 8] = {$urandom_range(0, 3) == 0, n[k*SS_W +: SS_W]};
        return w;
    endfunction

    task automatic add_bytes(input logic [79:0] w, input int n);
        for (int k = n - 1; k >= 0; k--)
            tag_bytes.push_back(w[k*8 +: 8]);
    endtask

    task automatic commit_bytes(input logic first_sof, input logic quiet, input int n);
        tag_byte_t item;
        for (int k = 0; k < n; k++) begin
            item.data = tag_bytes.pop_front();
            item.sof  = first_sof && (k == 0);
            item.calm = quiet;
            byte_plan.push_back(item);
        end
    endtask

    // Mostly well-formed tags; some padded, cut short, overrun or with a huge size.
    task automatic plan_random_tag(input logic [ID_W-1:0] want);
        logic [ID_W-1:0]   fid;
        logic [SIZE_W-1:0] tag_size;
        logic [31:0]       ss;
        logic [23:0]       ver_flags;
        logic [15:0]       fflags;
        logic              quiet;
        int                nframes;
        int                fsize;
        int                roll;
        int                body_len;
        int                keep;
        tag_bytes.delete();
        ver_flags = 24'($urandom);
        add_bytes({"ID3", ver_flags, 32'h0}, 10);
        nframes = $urandom_range(0, 5);
        for (int f = 0; f < nframes; f++) begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
                fid = want;
            else if (roll < 8)
                fid = known_id($urandom_range(0, 5));
            else
                fid = $urandom;
            roll = $urandom_range(0, 15);
            if (roll < 2)
                fsize = 0;
            else if (roll < 4)
                fsize = 1;
            else if (roll == 4)
                fsize = $urandom_range(20, 40);
            else
                fsize = $urandom_range(2, 10);
            fflags = 16'($urandom);
            add_bytes({fid, syncsafe(SIZE_W'(fsize)), fflags}, 10);
            if (fsize > 0) begin
                case ($urandom_range(0, 3))
                    0:       add_bytes(80'h00, 1);
                    1:       add_bytes(80'h01, 1);
                    default: add_bytes(80'($urandom), 1);
                endcase
                repeat (fsize - 1) add_bytes(80'($urandom), 1);
            end
        end
        body_len = tag_bytes.size() - 10;
        tag_size = SIZE_W'(body_len);
        roll = $urandom_range(0, 19);
        if (roll < 3) begin
            repeat ($urandom_range(1, 6)) add_bytes(80'h00, 1);
            tag_size = SIZE_W'(tag_bytes.size() - 10);
        end else if (roll < 6 && body_len > 1) begin
            tag_size = SIZE_W'($urandom_range(1, body_len - 1));
        end else if (roll < 8) begin
            repeat ($urandom_range(1, 12)) add_bytes(80'($urandom), 1);
            tag_size = SIZE_W'(tag_bytes.size() - 10);
        end else if (roll == 8) begin
            tag_size = SIZE_W'($urandom);
        end
        ss = syncsafe(tag_size);
        for (int k = 0; k < 4; k++)
            tag_bytes[6 + k] = ss[(3 - k)*8 +: 8];
        keep = tag_bytes.size();
        if ($urandom_range(0, 9) == 0)
            keep = $urandom_range(1, keep - 1);
        quiet = ($urandom_range(0, 4) == 0);
        commit_bytes($urandom_range(0, 19) != 0, quiet, keep);
        tag_bytes.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) add_bytes(80'($urandom), 1);
            commit_bytes(1'b0, quiet, tag_bytes.size());
        end
    endtask

    task automatic send_plan();
        tag_byte_t item;
        int        gap;
        while (byte_plan.size() != 0) begin
            item = byte_plan.pop_front();
            gap  = item.calm ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid   <= 1'b1;
            data_byte  <= item.data;
            start_mark <= item.sof;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
        end
        in_valid <= 1'b0;
    endtask

    // Wait for every predicted result, then let the pipe drain with no byte sent.
    task automatic settle();
        do @(posedge clk); while (bytes_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_target(input logic [ID_W-1:0] id);
        cfg_we   <= 1'b1;
        cfg_data <= id;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Result side: random stalls, calm stretches and an occasional long hold-off.
    initial begin : result_sink
        int gap;
        int calm_left;
        out_ready = 1'b0;
        calm_left = 0;
        wait (rst_n);
        forever begin
            if (calm_left > 0) begin
                gap = 0;
                calm_left--;
            end else begin
                gap = $urandom_range(0, 8);
                if ($urandom_range(0, 19) == 0)
                    calm_left = $urandom_range(10, 40);
            end
            if (rx_seen % 250 == 10)
                gap = HOLD_OFF;
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            rx_seen++;
        end
    end

    initial begin : stimulus
        logic [ID_W-1:0] want;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        data_byte  = '0;
        start_mark = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No start mark after reset, zero tag size with all top bits set, then an ignored byte.
        add_bytes({"ID3", 8'h04, 8'h00, 8'h00, 32'h8080_8080}, 10);
        add_bytes(80'hFF, 1);
        commit_bytes(1'b0, 1'b1, 11);
        // Tag ends inside a TIT2 payload; the ID register changes mid header.
        add_bytes({"ID3", 8'h03, 8'h00, 8'h00, 32'h0000_000D}, 10);
        add_bytes({"TIT2", 32'h0000_0004, 16'hFFFF}, 10);
        add_bytes(80'({8'hFF, 8'h00, 8'hFF, 8'h7F}), 4);
        commit_bytes(1'b1, 1'b0, 15);
        send_plan();
        settle();
        want = "TIT2";
        load_target(want);
        commit_bytes(1'b0, 1'b0, 9);
        send_plan();
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                1:       want = 32'hFFFF_FFFF;
                2:       want = '0;
                3:       want = $urandom;
                4:       want = "TALB";
                5:       want = TARGET_RESET;
                default: ;
            endcase
            if (p != 0)
                load_target(want);
            while (byte_plan.size() < PHASE_BYTES)
                plan_random_tag(want);
            send_plan();
            settle();
        end

        if (n_failed == 0)
            $display("PASS id3v2_frame_text_extractor");
        else
            $display("FAIL id3v2_frame_text_extractor");
        $finish;
    end

endmodule
